// ===== sv/gsv_pkg.sv =====
// Shared types, constants and helper functions of the grid sector vertex generator.
// No dependencies; every other file imports this package.
`default_nettype none

package gsv_pkg;

  localparam int MAX_DIVISIONS = 255;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_SHAPE_MODE  = 3'd0;
  localparam logic [2:0] REG_NUM_COLS    = 3'd1;
  localparam logic [2:0] REG_NUM_ROWS    = 3'd2;
  localparam logic [2:0] REG_TEX_ORIGIN  = 3'd3;
  localparam logic [2:0] REG_TEX_SIZE    = 3'd4;
  localparam logic [2:0] REG_GAIN_A      = 3'd5;
  localparam logic [2:0] REG_GAIN_B      = 3'd6;
  localparam logic [2:0] REG_SWEEP_ANGLE = 3'd7;

  // pipelined divider: dividend width, bits per stage
  localparam int DIV_W      = 24;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_BITS;
  localparam int DIV_REM_W  = 8;

  // CORDIC datapath widths
  localparam int X_W = 36;
  localparam int Z_W = 28;

  localparam logic signed [Z_W-1:0] PI_Q24      = 52707179;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 26353589;
  localparam logic signed [Z_W-1:0] TWO_PI_Q24  = 105414357;
  localparam logic signed [24:0]    GAIN_Q24    = 25'sd10188014;
  // floor(2^40 / TWO_PI_Q24); estimate of the turn count is low by at most one
  localparam logic [13:0] TWO_PI_RCP = 14'd10430;
  localparam int          RCP_SHIFT  = 40;

  localparam logic signed [Z_W-1:0] ATAN_Q24 [ATAN_ENTRIES] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic [7:0] grid_col;
    logic [7:0] grid_row;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic [15:0]        vertex_index;
    logic               out_of_range;
  } out_t;

  typedef struct packed {
    logic               shape_mode;
    logic [7:0]         num_cols;
    logic [7:0]         num_rows;
    logic [31:0]        tex_origin;
    logic [31:0]        tex_size;
    logic signed [23:0] gain_a;
    logic signed [23:0] gain_b;
    logic signed [15:0] sweep_angle;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    shape_mode:  1'b0,
    num_cols:    8'd1,
    num_rows:    8'd1,
    tex_origin:  32'h0000_0000,
    tex_size:    32'h1000_1000,
    gain_a:      24'sd256,
    gain_b:      24'sd256,
    sweep_angle: 16'sd25736
  };

  typedef struct packed {
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic [15:0]        vertex_index;
    logic               out_of_range;
  } front_t;

  typedef struct packed {
    logic sector;
    out_t res;
  } side_t;

  typedef struct packed {
    logic signed [X_W-1:0] x0;
    logic signed [Z_W-1:0] z;
    logic                  flip;
    side_t                 side;
  } cin_t;

  function automatic logic [7:0] clamp_div(input logic [7:0] n);
    if (n == 8'd0) begin
      return 8'd1;
    end else if (n > 8'(MAX_DIVISIONS)) begin
      return 8'(MAX_DIVISIONS);
    end
    return n;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) begin
      return 16'sd32767;
    end else if (v < -26'sd32768) begin
      return -16'sd32768;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

endpackage

`default_nettype wire

// ===== sv/gsv_divider.sv =====
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Depends on gsv_pkg; the divisor must stay stable while items are in flight.
`default_nettype none

module gsv_divider import gsv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_W-1:0]     num_i,
  input  logic [DIV_REM_W-1:0] den_i,
  output logic [DIV_W-1:0]     quo_o
);

  logic [DIV_REM_W-1:0] rem_q [DIV_STAGES-1];
  logic [DIV_W-1:0]     wrk_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_REM_W-1:0] rem_in, rem_d;
    logic [DIV_W-1:0]     wrk_in, wrk_d;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign wrk_in = num_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign wrk_in = wrk_q[s-1];
    end

    // quotient bits shift into the low end of the work word
    always_comb begin
      logic [DIV_REM_W:0] t;
      rem_d = rem_in;
      wrk_d = wrk_in;
      for (int b = 0; b < DIV_BITS; b++) begin
        t     = {rem_d, wrk_d[DIV_W-1]};
        wrk_d = {wrk_d[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          t        = t - {1'b0, den_i};
          wrk_d[0] = 1'b1;
        end
        rem_d = t[DIV_REM_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wrk_q[s] <= wrk_d;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
        end
      end
    end
  end

  assign quo_o = wrk_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/gsv_front.sv =====
// Front end: range check, vertex index and texture interpolation u, v.
// Depends on gsv_pkg and gsv_divider (one divider per axis).
`default_nettype none

module gsv_front import gsv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  in_t    data_i,
  input  cfg_t   cfg_i,
  output logic   valid_o,
  output front_t data_o
);

  localparam int L = DIV_STAGES - 1;

  logic [7:0]         nc, nr;
  logic signed [24:0] tu_d, tv_d;
  logic [16:0]        idx_full;

  logic               s1_vld_q;
  logic signed [24:0] s1_tu_q, s1_tv_q;
  logic               s1_oor_q;
  logic [15:0]        s1_idx_q;

  logic [DIV_W-1:0]      num_u, num_v, quo_u, quo_v;
  logic [DIV_STAGES-1:0] dv_vld_q, dv_sgnu_q, dv_sgnv_q, dv_oor_q;
  logic [15:0]           dv_idx_q [DIV_STAGES];

  logic signed [25:0] qu, qv;
  logic signed [15:0] u_d, v_d;

  function automatic logic [DIV_W-1:0] mag(input logic signed [24:0] v);
    return DIV_W'(v[24] ? -v : v);
  endfunction

  assign nc = clamp_div(cfg_i.num_cols);
  assign nr = clamp_div(cfg_i.num_rows);

  assign tu_d = 25'($signed({1'b0, data_i.grid_col})) * 25'($signed(cfg_i.tex_size[31:16]));
  assign tv_d = 25'($signed({1'b0, data_i.grid_row})) * 25'($signed(cfg_i.tex_size[15:0]));
  assign idx_full = 17'(data_i.grid_row) * 17'({1'b0, nc} + 9'd1) + 17'(data_i.grid_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      dv_vld_q <= '0;
      valid_o  <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      dv_vld_q <= {dv_vld_q[DIV_STAGES-2:0], s1_vld_q};
      valid_o  <= dv_vld_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_tu_q  <= tu_d;
      s1_tv_q  <= tv_d;
      s1_oor_q <= (data_i.grid_col > nc) || (data_i.grid_row > nr);
      s1_idx_q <= idx_full[15:0];
    end
  end

  // rounding to nearest: add half the divisor to the magnitude
  assign num_u = mag(s1_tu_q) + DIV_W'(nc >> 1);
  assign num_v = mag(s1_tv_q) + DIV_W'(nr >> 1);

  gsv_divider u_div_u (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_u),
    .den_i (nc),
    .quo_o (quo_u)
  );

  gsv_divider u_div_v (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_v),
    .den_i (nr),
    .quo_o (quo_v)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_sgnu_q   <= {dv_sgnu_q[DIV_STAGES-2:0], s1_tu_q[24]};
      dv_sgnv_q   <= {dv_sgnv_q[DIV_STAGES-2:0], s1_tv_q[24]};
      dv_oor_q    <= {dv_oor_q[DIV_STAGES-2:0], s1_oor_q};
      dv_idx_q[0] <= s1_idx_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_idx_q[k] <= dv_idx_q[k-1];
      end
    end
  end

  assign qu  = dv_sgnu_q[L] ? -$signed(26'(quo_u)) : $signed(26'(quo_u));
  assign qv  = dv_sgnv_q[L] ? -$signed(26'(quo_v)) : $signed(26'(quo_v));
  assign u_d = sat16(qu + 26'($signed(cfg_i.tex_origin[31:16])));
  assign v_d = sat16(qv + 26'($signed(cfg_i.tex_origin[15:0])));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o.out_of_range <= dv_oor_q[L];
      if (dv_oor_q[L]) begin
        data_o.tex_u        <= '0;
        data_o.tex_v        <= '0;
        data_o.vertex_index <= '0;
      end else begin
        data_o.tex_u        <= u_d;
        data_o.tex_v        <= v_d;
        data_o.vertex_index <= dv_idx_q[L];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/gsv_geom.sv =====
// Geometry stages: grid positions, sector radius and angle reduction to [-pi/2, pi/2].
// Depends on gsv_pkg; feeds gsv_cordic.
`default_nettype none

module gsv_geom import gsv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  front_t data_i,
  input  cfg_t   cfg_i,
  output logic   valid_o,
  output cin_t   data_o
);

  logic [5:0] vld_q;

  // stage 1: products
  logic signed [17:0] omv;
  logic signed [24:0] gdif;
  logic signed [39:0] g1_pgx_q;
  logic signed [41:0] g1_pgy_q;
  logic signed [33:0] g1_th_q;
  logic signed [40:0] g1_dd_q;
  side_t              g1_side_q;

  // stage 2: grid rounding, radius in Q.12, angle magnitude
  side_t              side2_d;
  logic signed [33:0] g2_d12_q;
  logic [30:0]        g2_m_q;
  logic               g2_ts_q;
  side_t              g2_side_q;

  // stage 3: gain and turn-count products
  logic signed [57:0] g3_x0p_q;
  logic [44:0]        g3_kp_q;
  logic [30:0]        g3_m_q;
  logic               g3_ts_q;
  side_t              g3_side_q;

  // stage 4: remainder estimate
  logic [4:0]            k0;
  logic signed [X_W-1:0] g4_x0_q;
  logic [27:0]           g4_r0_q;
  logic                  g4_ts_q;
  side_t                 g4_side_q;

  // stage 5: remainder correction and sign
  logic [27:0]           r5;
  logic signed [X_W-1:0] g5_x0_q;
  logic signed [Z_W-1:0] g5_r_q;
  side_t                 g5_side_q;

  // stage 6: fold into the right half plane
  logic signed [Z_W-1:0] r1;
  cin_t                  g6_q;

  assign omv  = 18'sd4096 - 18'(data_i.tex_v);
  assign gdif = 25'(cfg_i.gain_a) - 25'(cfg_i.gain_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_pgx_q <= 40'(cfg_i.gain_a) * 40'(data_i.tex_u);
      g1_pgy_q <= 42'(cfg_i.gain_b) * 42'(omv);
      g1_th_q  <= 34'(omv) * 34'(cfg_i.sweep_angle);
      g1_dd_q  <= 41'(gdif) * 41'(data_i.tex_u);
      g1_side_q.sector                 <= cfg_i.shape_mode;
      g1_side_q.res.pos_x              <= '0;
      g1_side_q.res.pos_y              <= '0;
      g1_side_q.res.tex_u              <= data_i.tex_u;
      g1_side_q.res.tex_v              <= data_i.tex_v;
      g1_side_q.res.vertex_index       <= data_i.vertex_index;
      g1_side_q.res.out_of_range       <= data_i.out_of_range;
    end
  end

  always_comb begin
    side2_d           = g1_side_q;
    side2_d.res.pos_x = sat32(44'((g1_pgx_q + 40'sd2048) >>> 12));
    side2_d.res.pos_y = sat32(44'((g1_pgy_q + 42'sd2048) >>> 12));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g2_side_q <= side2_d;
      g2_d12_q <= 34'((42'(g1_dd_q) + (42'(cfg_i.gain_b) <<< 12) + 42'sd128) >>> 8);
      g2_m_q   <= 31'(g1_th_q[33] ? -g1_th_q : g1_th_q);
      g2_ts_q  <= g1_th_q[33];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g3_x0p_q  <= 58'(g2_d12_q) * 58'(GAIN_Q24);
      g3_kp_q   <= 45'(g2_m_q) * 45'(TWO_PI_RCP);
      g3_m_q    <= g2_m_q;
      g3_ts_q   <= g2_ts_q;
      g3_side_q <= g2_side_q;
    end
  end

  assign k0 = 5'(g3_kp_q >> RCP_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g4_x0_q   <= X_W'(g3_x0p_q >>> 24);
      g4_r0_q   <= 28'(g3_m_q - (31'(k0) * 31'(TWO_PI_Q24)));
      g4_ts_q   <= g3_ts_q;
      g4_side_q <= g3_side_q;
    end
  end

  assign r5 = (g4_r0_q >= 28'(TWO_PI_Q24)) ? g4_r0_q - 28'(TWO_PI_Q24) : g4_r0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g5_x0_q   <= g4_x0_q;
      g5_r_q    <= g4_ts_q ? -$signed(r5) : $signed(r5);
      g5_side_q <= g4_side_q;
    end
  end

  always_comb begin
    if (g5_r_q > PI_Q24) begin
      r1 = g5_r_q - TWO_PI_Q24;
    end else if (g5_r_q < -PI_Q24) begin
      r1 = g5_r_q + TWO_PI_Q24;
    end else begin
      r1 = g5_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g6_q.x0   <= g5_x0_q;
      g6_q.side <= g5_side_q;
      if (r1 > HALF_PI_Q24) begin
        g6_q.z    <= r1 - PI_Q24;
        g6_q.flip <= 1'b1;
      end else if (r1 < -HALF_PI_Q24) begin
        g6_q.z    <= r1 + PI_Q24;
        g6_q.flip <= 1'b1;
      end else begin
        g6_q.z    <= r1;
        g6_q.flip <= 1'b0;
      end
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = g6_q;

endmodule

`default_nettype wire

// ===== sv/gsv_cordic.sv =====
// Rotation-mode CORDIC, one iteration per pipeline stage, then rounding to Q24.8.
// Depends on gsv_pkg; selects grid or sector position and zeroes out-of-range points.
`default_nettype none

module gsv_cordic import gsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  cin_t data_i,
  output logic valid_o,
  output out_t res_o
);

  localparam int L = CORDIC_N - 1;

  logic [CORDIC_N-1:0]   vld_q, flip_q;
  logic signed [X_W-1:0] x_q [CORDIC_N];
  logic signed [X_W-1:0] y_q [CORDIC_N];
  logic signed [Z_W-1:0] z_q [CORDIC_N-1];
  side_t                 side_q [CORDIC_N];

  logic signed [X_W-1:0] xf, yf;
  logic signed [31:0]    px, py;
  out_t                  res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[CORDIC_N-2:0], valid_i};
      valid_o <= vld_q[L];
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
    logic signed [X_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [Z_W-1:0] z_in, z_d;
    logic                  flip_in;
    side_t                 side_in;

    if (i == 0) begin : g_first
      assign x_in    = data_i.x0;
      assign y_in    = '0;
      assign z_in    = data_i.z;
      assign flip_in = data_i.flip;
      assign side_in = data_i.side;
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign flip_in = flip_q[i-1];
      assign side_in = side_q[i-1];
    end

    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - ATAN_Q24[i];
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + ATAN_Q24[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        flip_q[i] <= flip_in;
        side_q[i] <= side_in;
      end
    end

    // the angle left after the last iteration is not needed
    if (i < L) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= z_d;
        end
      end
    end
  end

  assign xf = flip_q[L] ? -x_q[L] : x_q[L];
  assign yf = flip_q[L] ? -y_q[L] : y_q[L];
  assign px = sat32(44'((xf + 36'sd8) >>> 4));
  assign py = sat32(44'((yf + 36'sd8) >>> 4));

  always_comb begin
    res_d = side_q[L].res;
    if (side_q[L].res.out_of_range) begin
      res_d.pos_x = '0;
      res_d.pos_y = '0;
    end else if (side_q[L].sector) begin
      res_d.pos_x = px;
      res_d.pos_y = py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/grid_sector_vertex_generator_core.sv =====
// Channel    | Direction | Payload       | Transaction when
// ---------- | --------- | ------------- | ------------------------------------
// input      | in        | in_t          | in_valid_i high, in_stall_o low
// output     | out       | out_t         | out_valid_o high, out_stall_i low
// config     | in/out    | 32-bit APB    | psel, penable, pwrite, pready high
//
// One grid point per cycle while in_stall_o is low; each result passes through the
// pipeline stages (8 front stages incl. the 6-stage divider, 6 geometry stages,
// one stage per CORDIC iteration, rounding, output register).
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A two-entry output buffer (output register plus skid) takes the pipeline's
// result while the output stalls; in_stall_o rises only when the skid is full.
// Depends on gsv_pkg, gsv_front, gsv_geom, gsv_cordic.
`default_nettype none

module grid_sector_vertex_generator_core import gsv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic   en;
  logic   front_vld, geom_vld, core_vld;
  front_t front_data;
  cin_t   geom_data;
  out_t   core_res;

  logic push, pop;
  logic skid_vld_q;
  out_t skid_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SHAPE_MODE:  cfg_q.shape_mode  <= pwdata[0];
        REG_NUM_COLS:    cfg_q.num_cols    <= pwdata[7:0];
        REG_NUM_ROWS:    cfg_q.num_rows    <= pwdata[7:0];
        REG_TEX_ORIGIN:  cfg_q.tex_origin  <= pwdata;
        REG_TEX_SIZE:    cfg_q.tex_size    <= pwdata;
        REG_GAIN_A:      cfg_q.gain_a      <= $signed(pwdata[23:0]);
        REG_GAIN_B:      cfg_q.gain_b      <= $signed(pwdata[23:0]);
        REG_SWEEP_ANGLE: cfg_q.sweep_angle <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SHAPE_MODE:  prdata = {31'd0, cfg_q.shape_mode};
      REG_NUM_COLS:    prdata = {24'd0, cfg_q.num_cols};
      REG_NUM_ROWS:    prdata = {24'd0, cfg_q.num_rows};
      REG_TEX_ORIGIN:  prdata = cfg_q.tex_origin;
      REG_TEX_SIZE:    prdata = cfg_q.tex_size;
      REG_GAIN_A:      prdata = {8'd0, cfg_q.gain_a};
      REG_GAIN_B:      prdata = {8'd0, cfg_q.gain_b};
      REG_SWEEP_ANGLE: prdata = {16'd0, cfg_q.sweep_angle};
      default:         prdata = '0;
    endcase
  end

  // whole pipeline advances unless the skid entry is occupied
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  gsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (front_vld),
    .data_o  (front_data)
  );

  gsv_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_vld),
    .data_i  (front_data),
    .cfg_i   (cfg_q),
    .valid_o (geom_vld),
    .data_o  (geom_data)
  );

  gsv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geom_vld),
    .data_i  (geom_data),
    .valid_o (core_vld),
    .res_o   (core_res)
  );

  assign push = core_vld && en;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      skid_vld_q  <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_o && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_valid_o <= 1'b1;
      end
    end else if (pop) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_data_o <= skid_q;
      end
    end else if (push) begin
      if (out_valid_o && !pop) begin
        skid_q <= core_res;
      end else begin
        out_data_o <= core_res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/gsv_checker.sv =====
// Port-level checks for grid_sector_vertex_generator_core, bound to the top level.
// Depends on gsv_pkg.
`default_nettype none

module gsv_port_checker import gsv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input in_t               in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input out_t              out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  // a stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  // out-of-range points carry only the flag
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_range |->
      out_data_o.pos_x == '0 && out_data_o.pos_y == '0 && out_data_o.tex_u == '0 &&
      out_data_o.tex_v == '0 && out_data_o.vertex_index == '0)
    else $error("out-of-range result has nonzero fields");

  // the input only backs up when the output is occupied
  a_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without a stalled output");

endmodule

bind grid_sector_vertex_generator_core gsv_port_checker u_gsv_checker (.*);

`default_nettype wire

// ===== verif/gsv_checker.sv =====
// Checker for the grid sector vertex generator: predicts each vertex from the
// point transactions and compares against the output transactions.
// Depends on gsv_pkg; configuration is mirrored from the APB write port.
module gsv_checker import gsv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_t              out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ARC_PI      = 64'd52707179;
  localparam longint ARC_HALF_PI = 64'd26353589;
  localparam longint ARC_TWO_PI  = 64'd105414357;
  localparam longint CORDIC_K    = 64'd10188014;

  cfg_t   regs;
  out_t   vertex_q[$];
  longint arctan_tbl[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint lerp_tex(longint pos, longint n, longint span, longint base);
    longint t, mag, q;
    t = pos * span;
    mag = (t < 0) ? -t : t;
    q = (mag + n / 2) / n;
    if (t < 0) q = -q;
    return clip(q + base, 16);
  endfunction

  function automatic out_t vertex_of(in_t pt);
    out_t   r;
    longint nc, nr, u, v, ga, gb, px, py, theta, d12, ang, x, y, z, dx, dy;
    bit     flip;
    int     stages;
    nc = (regs.num_cols == 0) ? 1 : longint'(regs.num_cols);
    nr = (regs.num_rows == 0) ? 1 : longint'(regs.num_rows);
    r = '0;
    if (pt.grid_col > nc || pt.grid_row > nr) begin
      r.out_of_range = 1'b1;
      return r;
    end
    u = lerp_tex(pt.grid_col, nc, longint'($signed(regs.tex_size[31:16])),
                 longint'($signed(regs.tex_origin[31:16])));
    v = lerp_tex(pt.grid_row, nr, longint'($signed(regs.tex_size[15:0])),
                 longint'($signed(regs.tex_origin[15:0])));
    ga = longint'(regs.gain_a);
    gb = longint'(regs.gain_b);
    if (!regs.shape_mode) begin
      px = clip(floor_shift(ga * u + 2048, 12), 32);
      py = clip(floor_shift(gb * (4096 - v) + 2048, 12), 32);
    end else begin
      theta = (4096 - v) * longint'(regs.sweep_angle);
      d12 = floor_shift((ga - gb) * u + gb * 4096 + 128, 8);
      ang = theta % ARC_TWO_PI;
      flip = 1'b0;
      if (ang > ARC_PI) ang -= ARC_TWO_PI;
      if (ang < -ARC_PI) ang += ARC_TWO_PI;
      if (ang > ARC_HALF_PI) begin
        ang -= ARC_PI;
        flip = 1'b1;
      end else if (ang < -ARC_HALF_PI) begin
        ang += ARC_PI;
        flip = 1'b1;
      end
      stages = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
      x = floor_shift(d12 * CORDIC_K, 24);
      y = 0;
      z = ang;
      for (int i = 0; i < stages; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_tbl[i];
        end else begin
          x += dx; y -= dy; z += arctan_tbl[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      px = clip(floor_shift(x + 8, 4), 32);
      py = clip(floor_shift(y + 8, 4), 32);
    end
    r.pos_x = px[31:0];
    r.pos_y = py[31:0];
    r.tex_u = u[15:0];
    r.tex_v = v[15:0];
    r.vertex_index = 16'(longint'(pt.grid_col) + longint'(pt.grid_row) * (nc + 1));
    return r;
  endfunction

  assign pending_o = vertex_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      regs <= CFG_RESET;
      vertex_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_SHAPE_MODE:  regs.shape_mode  <= pwdata_i[0];
          REG_NUM_COLS:    regs.num_cols    <= pwdata_i[7:0];
          REG_NUM_ROWS:    regs.num_rows    <= pwdata_i[7:0];
          REG_TEX_ORIGIN:  regs.tex_origin  <= pwdata_i;
          REG_TEX_SIZE:    regs.tex_size    <= pwdata_i;
          REG_GAIN_A:      regs.gain_a      <= pwdata_i[23:0];
          REG_GAIN_B:      regs.gain_b      <= pwdata_i[23:0];
          REG_SWEEP_ANGLE: regs.sweep_angle <= pwdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex transaction");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = vertex_q.pop_front();
          if (out_data_i !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (out_data_i.pos_x !== want.pos_x)
              $error("pos_x exp %0d got %0d", want.pos_x, out_data_i.pos_x);
            if (out_data_i.pos_y !== want.pos_y)
              $error("pos_y exp %0d got %0d", want.pos_y, out_data_i.pos_y);
            if (out_data_i.tex_u !== want.tex_u)
              $error("tex_u exp %0d got %0d", want.tex_u, out_data_i.tex_u);
            if (out_data_i.tex_v !== want.tex_v)
              $error("tex_v exp %0d got %0d", want.tex_v, out_data_i.tex_v);
            if (out_data_i.vertex_index !== want.vertex_index)
              $error("vertex_index exp %0d got %0d", want.vertex_index,
                     out_data_i.vertex_index);
            if (out_data_i.out_of_range !== want.out_of_range)
              $error("out_of_range exp %0d got %0d", want.out_of_range,
                     out_data_i.out_of_range);
          end
        end
      end
      // config only changes while idle, so current regs apply
      if (in_valid_i && !in_stall_i) vertex_q.push_back(vertex_of(in_data_i));
    end
  end
endmodule

// ===== verif/grid_sector_vertex_generator_core_test.sv =====
// Top of the vertex generator testbench: clock, reset, APB setup and point stimulus.
// Depends on gsv_pkg, grid_sector_vertex_generator_core and gsv_checker.
module grid_sector_vertex_generator_core_test;
  import gsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_t               in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count, pending;
  int                cycle_count = 0;
  bit                calm = 1'b0;
  logic [7:0]        cols_now = 8'd1, rows_now = 8'd1;

  grid_sector_vertex_generator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gsv_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_NUM_COLS) cols_now = val[7:0];
    if (idx == REG_NUM_ROWS) rows_now = val[7:0];
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_point(logic [7:0] c, logic [7:0] r);
    int n;
    if (!calm && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{grid_col: c, grid_row: r};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic random_point();
    int nc, nr;
    nc = (cols_now == 0) ? 1 : cols_now;
    nr = (rows_now == 0) ? 1 : rows_now;
    if ($urandom_range(0, 9) == 0)
      send_point(8'($urandom), 8'($urandom));
    else
      send_point(8'($urandom_range(0, nc)), 8'($urandom_range(0, nr)));
  endtask

  task automatic random_config(int mode);
    reg_write(REG_SHAPE_MODE, 32'(mode));
    reg_write(REG_NUM_COLS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 16));
    reg_write(REG_NUM_ROWS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 16));
    reg_write(REG_TEX_ORIGIN, $urandom);
    reg_write(REG_TEX_SIZE, $urandom);
    reg_write(REG_GAIN_A, $urandom);
    reg_write(REG_GAIN_B, $urandom);
    reg_write(REG_SWEEP_ANGLE, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: corners, out of range on each axis
    send_point(0, 0); send_point(1, 0); send_point(0, 1); send_point(1, 1);
    send_point(2, 0); send_point(0, 2); send_point(255, 255);
    in_valid_i <= 1'b0;
    wait_idle();

    // extremes: zero grid size clamps to 1, max size, saturating gains
    reg_write(REG_SHAPE_MODE, 1);
    reg_write(REG_NUM_COLS, 0);
    reg_write(REG_NUM_ROWS, 255);
    reg_write(REG_TEX_ORIGIN, 32'h7FFF_8000);
    reg_write(REG_TEX_SIZE, 32'h7FFF_8000);
    reg_write(REG_GAIN_A, 32'h7F_FFFF);
    reg_write(REG_GAIN_B, 32'h80_0000);
    reg_write(REG_SWEEP_ANGLE, 32'h8000);
    send_point(0, 0); send_point(1, 255); send_point(1, 128); send_point(2, 3);
    in_valid_i <= 1'b0;
    wait_idle();
    reg_write(REG_SHAPE_MODE, 0);
    reg_write(REG_SWEEP_ANGLE, 32'h7FFF);
    reg_write(REG_TEX_ORIGIN, 32'h8000_7FFF);
    send_point(0, 255); send_point(1, 0); send_point(1, 127);
    in_valid_i <= 1'b0;
    wait_idle();
    reg_write(REG_NUM_COLS, 255);
    send_point(255, 255); send_point(128, 0); send_point(170, 85);
    in_valid_i <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 16; ph++) begin
      random_config(ph % 2);
      repeat (95) random_point();
      // hold the sender until the pipe has drained once
      in_valid_i <= 1'b0;
      wait_idle();
    end
    calm = 1'b1;
    repeat (40) random_point();
    in_valid_i <= 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
